// ----- rtl/core/aemanf_pkg.sv -----
// Shared constants, register codes and pipeline types of the noise-floor tracker.
// Used by the channel interfaces and by the top level; depends on nothing.

package aemanf_pkg;

   localparam int NUM_BINS    = 4096;
   localparam int SAMPLE_BITS = 24;

   localparam int BIN_W   = 12;
   localparam int ADDR_W  = $clog2(NUM_BINS);
   localparam int FRAC_W  = 16;
   localparam int FLOOR_W = 41;
   localparam int HEAD_W  = FLOOR_W - FRAC_W;
   localparam int RATE_W  = 16;
   localparam int WARM_W  = 4;
   localparam int PASS_W  = 4;

   localparam int SUM_W       = 2 * SAMPLE_BITS;
   localparam int ROOT_STAGES = SAMPLE_BITS;
   localparam int MAG_W       = SAMPLE_BITS;
   localparam int SCALED_W    = (MAG_W + FRAC_W > FLOOR_W) ? MAG_W + FRAC_W : FLOOR_W;
   localparam int BLEND_W     = RATE_W + HEAD_W + 3;

   localparam logic [PASS_W-1:0]  PASS_MAX  = '1;
   localparam logic [FLOOR_W-1:0] FLOOR_MAX = '1;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RATE_DOWN_WARM = 3'd0,
      CSR_RATE_UP_WARM   = 3'd1,
      CSR_RATE_DOWN      = 3'd2,
      CSR_RATE_UP        = 3'd3,
      CSR_WARMUP_PASSES  = 3'd4
   } csr_index_type;

   localparam logic [RATE_W-1:0] RATE_DOWN_WARM_RESET = 16'd19661;
   localparam logic [RATE_W-1:0] RATE_UP_WARM_RESET   = 16'd6554;
   localparam logic [RATE_W-1:0] RATE_DOWN_RESET      = 16'd6554;
   localparam logic [RATE_W-1:0] RATE_UP_RESET        = 16'd328;
   localparam logic [WARM_W-1:0] WARMUP_PASSES_RESET  = 4'd5;

   // Control that travels with each word down the pipeline.
   typedef struct packed {
      logic [BIN_W-1:0] bin;
      logic             warm;
      logic             seed;
      logic             hit;
   } item_ctl_type;

endpackage

// ----- rtl/core/aemanf_if.sv -----
// Valid/ready channel interfaces for the bin input and the floor result.
// Depends on aemanf_pkg for the field widths.

interface aemanf_req_if import aemanf_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic [BIN_W-1:0]              bin_index;
   logic signed [SAMPLE_BITS-1:0] re_part;
   logic signed [SAMPLE_BITS-1:0] im_part;
   logic                          last_of_pass;

   modport source (output valid, bin_index, re_part, im_part, last_of_pass, input ready);
   modport sink   (input valid, bin_index, re_part, im_part, last_of_pass, output ready);
endinterface

interface aemanf_rsp_if import aemanf_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [BIN_W-1:0]   out_bin;
   logic [FLOOR_W-1:0] floor_level;
   logic               in_warmup;

   modport source (output valid, out_bin, floor_level, in_warmup, input ready);
   modport sink   (input valid, out_bin, floor_level, in_warmup, output ready);
endinterface

// ----- rtl/core/aemanf_ram.sv -----
// Generic single-clock RAM, one write port and one read port, registered read.
// Self-contained; a read of the address being written returns the old contents.

module aemanf_ram #(
   parameter int  WIDTH  = 8,
   parameter int  DEPTH  = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

// ----- rtl/core/asymmetric_ema_noise_floor_top.sv -----
// Per-bin noise-floor tracker: takes one complex bin per word, forms its rounded
// magnitude and blends it into that bin's stored floor with an asymmetric moving
// average. Uses aemanf_pkg, aemanf_req_if/aemanf_rsp_if and aemanf_ram.
//
// One word is accepted per clock cycle while the output is not held and no interlock
// stall applies, and each word gives exactly one result. The floor memory is read
// from the rounding stage, then blended and written back in the update stages; a word
// whose bin is still being updated by one of the two words ahead of it in that loop
// holds the input until the result can be forwarded (never during the seeding pass).
// The floor memory needs no clearing after reset.

module asymmetric_ema_noise_floor_top import aemanf_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   aemanf_req_if.sink             req_ch,
   aemanf_rsp_if.source           rsp_ch,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   // Configuration registers.
   logic [RATE_W-1:0] rate_down_warm_ff;
   logic [RATE_W-1:0] rate_up_warm_ff;
   logic [RATE_W-1:0] rate_down_ff;
   logic [RATE_W-1:0] rate_up_ff;
   logic [WARM_W-1:0] warmup_passes_ff;
   logic [PASS_W-1:0] pass_count_ff;

   // Pipeline control.
   logic move;
   logic front_en;
   logic hazard;
   logic accept;

   // Front stages: absolute values, squares, sum.
   logic                   a_valid_ff;
   item_ctl_type           a_ctl_ff;
   logic [MAG_W-1:0]       a_re_abs_ff;
   logic [MAG_W-1:0]       a_im_abs_ff;
   logic [MAG_W-1:0]       re_abs_in;
   logic [MAG_W-1:0]       im_abs_in;
   item_ctl_type           a_ctl_in;
   logic                   q_valid_ff;
   item_ctl_type           q_ctl_ff;
   logic [SUM_W-1:0]       q_re_sq_ff;
   logic [SUM_W-1:0]       q_im_sq_ff;

   // Square-root stages, one result bit each.
   logic                   rt_valid_ff [0:ROOT_STAGES];
   item_ctl_type           rt_ctl_ff   [0:ROOT_STAGES];
   logic [SUM_W-1:0]       rt_rem_ff   [0:ROOT_STAGES];
   logic [SUM_W-1:0]       rt_root_ff  [0:ROOT_STAGES];

   // Rounding stage, which issues the memory read.
   logic                   rd_valid_ff;
   item_ctl_type           rd_ctl_ff;
   logic [FLOOR_W-1:0]     rd_m_ff;
   logic [SUM_W-1:0]       root_fin;
   logic [MAG_W-1:0]       mag_in;
   logic [SCALED_W-1:0]    scaled_in;
   logic [FLOOR_W-1:0]     m_in;

   // Update stages.
   logic                   e0_valid_ff;
   item_ctl_type           e0_ctl_ff;
   logic [FLOOR_W-1:0]     e0_m_ff;
   logic [FLOOR_W-1:0]     ram_rd_data;
   logic [FLOOR_W-1:0]     old_in;
   logic                   falling_in;
   logic [RATE_W-1:0]      rate_in;
   logic signed [HEAD_W:0] dh_in;
   logic signed [FRAC_W:0] dl_in;

   logic                   e1_valid_ff;
   item_ctl_type           e1_ctl_ff;
   logic [FLOOR_W-1:0]     e1_m_ff;
   logic [FLOOR_W-1:0]     e1_old_ff;
   logic [RATE_W-1:0]      e1_rate_ff;
   logic signed [HEAD_W:0] e1_dh_ff;
   logic signed [FRAC_W:0] e1_dl_ff;
   logic signed [RATE_W+HEAD_W+1:0] p_head_in;
   logic signed [RATE_W+FRAC_W+1:0] p_frac_in;

   logic                   e2_valid_ff;
   item_ctl_type           e2_ctl_ff;
   logic [FLOOR_W-1:0]     e2_m_ff;
   logic [FLOOR_W-1:0]     e2_old_ff;
   logic signed [RATE_W+HEAD_W+1:0] e2_p_head_ff;
   logic signed [RATE_W+FRAC_W+1:0] e2_p_frac_ff;
   logic signed [RATE_W+FRAC_W+1:0] frac_round;
   logic signed [BLEND_W-1:0]       blend_in;
   logic [FLOOR_W-1:0]     level_in;
   logic                   ram_wr_en;

   // Last write, for a read that coincides with it.
   logic                   wr_valid_ff;
   logic [BIN_W-1:0]       wr_bin_ff;
   logic [FLOOR_W-1:0]     wr_level_ff;

   // Output register.
   logic                   rsp_valid_ff;
   logic [BIN_W-1:0]       rsp_bin_ff;
   logic [FLOOR_W-1:0]     rsp_level_ff;
   logic                   rsp_warm_ff;

   // ---------------------------------------------------------------- control

   assign move = !rsp_valid_ff || rsp_ch.ready;

   // A word about to read its bin waits while an older word for the same bin is
   // still too far from its write-back for the result to be forwarded.
   assign hazard = rd_valid_ff && rd_ctl_ff.hit && !rd_ctl_ff.seed &&
                   ((e0_valid_ff && e0_ctl_ff.hit && e0_ctl_ff.bin == rd_ctl_ff.bin) ||
                    (e1_valid_ff && e1_ctl_ff.hit && e1_ctl_ff.bin == rd_ctl_ff.bin));

   assign front_en     = move && !hazard;
   assign req_ch.ready = front_en;
   assign accept       = req_ch.valid && front_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_down_warm_ff <= RATE_DOWN_WARM_RESET;
         rate_up_warm_ff   <= RATE_UP_WARM_RESET;
         rate_down_ff      <= RATE_DOWN_RESET;
         rate_up_ff        <= RATE_UP_RESET;
         warmup_passes_ff  <= WARMUP_PASSES_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_RATE_DOWN_WARM: rate_down_warm_ff <= csr_write_data[RATE_W-1:0];
            CSR_RATE_UP_WARM:   rate_up_warm_ff   <= csr_write_data[RATE_W-1:0];
            CSR_RATE_DOWN:      rate_down_ff      <= csr_write_data[RATE_W-1:0];
            CSR_RATE_UP:        rate_up_ff        <= csr_write_data[RATE_W-1:0];
            CSR_WARMUP_PASSES:  warmup_passes_ff  <= csr_write_data[WARM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_count_ff <= '0;
      end else if (accept && req_ch.last_of_pass && pass_count_ff != PASS_MAX) begin
         pass_count_ff <= pass_count_ff + 1'b1;
      end
   end

   // ------------------------------------------------------------ front stages

   assign re_abs_in = req_ch.re_part[SAMPLE_BITS-1] ? MAG_W'(-req_ch.re_part)
                                                    : MAG_W'(req_ch.re_part);
   assign im_abs_in = req_ch.im_part[SAMPLE_BITS-1] ? MAG_W'(-req_ch.im_part)
                                                    : MAG_W'(req_ch.im_part);

   always_comb begin
      a_ctl_in.bin  = req_ch.bin_index;
      a_ctl_in.warm = pass_count_ff < PASS_W'(warmup_passes_ff);
      a_ctl_in.seed = pass_count_ff == '0;
      a_ctl_in.hit  = 32'(req_ch.bin_index) < 32'(NUM_BINS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff     <= 1'b0;
         q_valid_ff     <= 1'b0;
         rt_valid_ff[0] <= 1'b0;
      end else if (front_en) begin
         a_valid_ff     <= req_ch.valid;
         q_valid_ff     <= a_valid_ff;
         rt_valid_ff[0] <= q_valid_ff;
      end
      if (front_en) begin
         a_ctl_ff      <= a_ctl_in;
         a_re_abs_ff   <= re_abs_in;
         a_im_abs_ff   <= im_abs_in;
         q_ctl_ff      <= a_ctl_ff;
         q_re_sq_ff    <= SUM_W'(a_re_abs_ff) * SUM_W'(a_im_abs_ff == a_im_abs_ff ?
                                                       a_re_abs_ff : a_re_abs_ff);
         q_im_sq_ff    <= SUM_W'(a_im_abs_ff) * SUM_W'(a_im_abs_ff);
         rt_ctl_ff[0]  <= q_ctl_ff;
         rt_rem_ff[0]  <= q_re_sq_ff + q_im_sq_ff;
         rt_root_ff[0] <= '0;
      end
   end

   // Digit-by-digit square root, one result bit per stage.
   for (genvar k = 0; k < ROOT_STAGES; k++) begin : g_root
      localparam logic [SUM_W-1:0] ONE_BIT = SUM_W'(1) << (2 * (ROOT_STAGES - 1 - k));
      logic [SUM_W-1:0] trial;
      logic [SUM_W-1:0] rem_in;
      logic [SUM_W-1:0] root_in;

      always_comb begin
         trial = rt_root_ff[k] + ONE_BIT;
         if (rt_rem_ff[k] >= trial) begin
            rem_in  = rt_rem_ff[k] - trial;
            root_in = (rt_root_ff[k] >> 1) + ONE_BIT;
         end else begin
            rem_in  = rt_rem_ff[k];
            root_in = rt_root_ff[k] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            rt_valid_ff[k+1] <= 1'b0;
         end else if (front_en) begin
            rt_valid_ff[k+1] <= rt_valid_ff[k];
         end
         if (front_en) begin
            rt_ctl_ff[k+1]  <= rt_ctl_ff[k];
            rt_rem_ff[k+1]  <= rem_in;
            rt_root_ff[k+1] <= root_in;
         end
      end
   end

   // Round to nearest: the root goes up when the remainder exceeds it.
   assign root_fin  = (rt_rem_ff[ROOT_STAGES] > rt_root_ff[ROOT_STAGES]) ?
                      rt_root_ff[ROOT_STAGES] + 1'b1 : rt_root_ff[ROOT_STAGES];
   assign mag_in    = root_fin[MAG_W-1:0];
   assign scaled_in = SCALED_W'({mag_in, {FRAC_W{1'b0}}});
   assign m_in      = (scaled_in > SCALED_W'(FLOOR_MAX)) ? FLOOR_MAX
                                                         : scaled_in[FLOOR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else if (front_en) begin
         rd_valid_ff <= rt_valid_ff[ROOT_STAGES];
      end
      if (front_en) begin
         rd_ctl_ff <= rt_ctl_ff[ROOT_STAGES];
         rd_m_ff   <= m_in;
      end
   end

   // ------------------------------------------------------------ floor memory

   assign ram_wr_en = move && e2_valid_ff && e2_ctl_ff.hit;

   aemanf_ram #(
      .WIDTH (FLOOR_W),
      .DEPTH (NUM_BINS)
   ) u_floor_ram (
      .clock      (clock),
      .wr_en      (ram_wr_en),
      .wr_addr    (ADDR_W'(e2_ctl_ff.bin)),
      .wr_data    (level_in),
      .rd_en      (front_en),
      .rd_addr    (ADDR_W'(rd_ctl_ff.bin)),
      .rd_data_ff (ram_rd_data)
   );

   // ----------------------------------------------------------- update stages

   always_comb begin
      if (wr_valid_ff && wr_bin_ff == e0_ctl_ff.bin) begin
         old_in = wr_level_ff;
      end else begin
         old_in = ram_rd_data;
      end
      falling_in = e0_m_ff < old_in;
      if (e0_ctl_ff.warm) begin
         rate_in = falling_in ? rate_down_warm_ff : rate_up_warm_ff;
      end else begin
         rate_in = falling_in ? rate_down_ff : rate_up_ff;
      end
      // The difference is split at the binary point so that both products stay narrow.
      dh_in = $signed({1'b0, e0_m_ff[FLOOR_W-1:FRAC_W]}) -
              $signed({1'b0, old_in[FLOOR_W-1:FRAC_W]});
      dl_in = $signed({1'b0, e0_m_ff[FRAC_W-1:0]}) - $signed({1'b0, old_in[FRAC_W-1:0]});
   end

   assign p_head_in = $signed({1'b0, e1_rate_ff}) * e1_dh_ff;
   assign p_frac_in = $signed({1'b0, e1_rate_ff}) * e1_dl_ff;

   // new = old + a*(m - old)/2^16, rounded half up; the high part is already whole.
   assign frac_round = e2_p_frac_ff + $signed((RATE_W+FRAC_W+2)'(1) << (FRAC_W - 1));
   assign blend_in   = BLEND_W'($signed({1'b0, e2_old_ff})) + BLEND_W'(e2_p_head_ff) +
                       BLEND_W'(frac_round >>> FRAC_W);

   always_comb begin
      if (!e2_ctl_ff.hit) begin
         level_in = '0;
      end else if (e2_ctl_ff.seed) begin
         level_in = e2_m_ff;
      end else begin
         level_in = blend_in[FLOOR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e0_valid_ff  <= 1'b0;
         e1_valid_ff  <= 1'b0;
         e2_valid_ff  <= 1'b0;
         wr_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (move) begin
         e0_valid_ff  <= front_en && rd_valid_ff;
         e1_valid_ff  <= e0_valid_ff;
         e2_valid_ff  <= e1_valid_ff;
         wr_valid_ff  <= e2_valid_ff && e2_ctl_ff.hit;
         rsp_valid_ff <= e2_valid_ff;
      end
      if (move) begin
         e0_ctl_ff    <= rd_ctl_ff;
         e0_m_ff      <= rd_m_ff;
         e1_ctl_ff    <= e0_ctl_ff;
         e1_m_ff      <= e0_m_ff;
         e1_old_ff    <= old_in;
         e1_rate_ff   <= rate_in;
         e1_dh_ff     <= dh_in;
         e1_dl_ff     <= dl_in;
         e2_ctl_ff    <= e1_ctl_ff;
         e2_m_ff      <= e1_m_ff;
         e2_old_ff    <= e1_old_ff;
         e2_p_head_ff <= p_head_in;
         e2_p_frac_ff <= p_frac_in;
         wr_bin_ff    <= e2_ctl_ff.bin;
         wr_level_ff  <= level_in;
         rsp_bin_ff   <= e2_ctl_ff.bin;
         rsp_level_ff <= level_in;
         rsp_warm_ff  <= e2_ctl_ff.warm;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.out_bin     = rsp_bin_ff;
   assign rsp_ch.floor_level = rsp_level_ff;
   assign rsp_ch.in_warmup   = rsp_warm_ff;

`ifndef ASSERT_OFF
   // A blended floor always lies between the old floor and the new magnitude.
   a_blend_bounded: assert property (@(posedge clock) disable iff (reset)
      (e2_valid_ff && e2_ctl_ff.hit && !e2_ctl_ff.seed) |->
      ((level_in >= e2_old_ff && level_in <= e2_m_ff) ||
       (level_in >= e2_m_ff && level_in <= e2_old_ff)))
      else $error("blended floor outside old floor and magnitude");

   // The interlock keeps a dependent word out of the stage right behind its writer.
   a_no_close_repeat: assert property (@(posedge clock) disable iff (reset)
      (e0_valid_ff && e1_valid_ff && e0_ctl_ff.hit && e1_ctl_ff.hit &&
       !e0_ctl_ff.seed) |-> (e0_ctl_ff.bin != e1_ctl_ff.bin))
      else $error("dependent update entered the stage behind its writer");

   a_pass_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (pass_count_ff >= $past(pass_count_ff)))
      else $error("pass counter went backwards");
`endif

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for asymmetric_ema_noise_floor_top: drives bin words with bursty
// valid, stalls the result channel and compares every result against an in-bench predictor.
// Depends on aemanf_pkg, the aemanf_req_if/aemanf_rsp_if interfaces and the top level itself.

module tb_top;
   import aemanf_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int LATENCY     = SAMPLE_BITS + 8;
   localparam int SEED_WORDS  = 250;
   localparam int PHASES      = 9;
   localparam int PHASE_WORDS = 140;
   localparam int MAX_REPORTS = 10;
   localparam logic [63:0] RATE_ONE = 64'd65536;
   localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

   typedef struct {
      logic [BIN_W-1:0]              bin;
      logic signed [SAMPLE_BITS-1:0] re;
      logic signed [SAMPLE_BITS-1:0] im;
      logic                          last;
   } bin_word_t;

   typedef struct {
      logic [BIN_W-1:0]   bin;
      logic [FLOOR_W-1:0] level;
      logic               warm;
   } floor_word_t;

   typedef enum {MAG_ZERO, MAG_EXTREME, MAG_SMALL, MAG_MEDIUM, MAG_FULL} sample_kind_t;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   aemanf_req_if req_ch ();
   aemanf_rsp_if rsp_ch ();

   asymmetric_ema_noise_floor_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // Predictor state: its own copy of the floor memory, pass counter and rates.
   logic [FLOOR_W-1:0] floor_mem [NUM_BINS];
   logic [PASS_W-1:0]  passes_done;
   logic [RATE_W-1:0]  fall_warm, rise_warm, fall_rate, rise_rate;
   logic [WARM_W-1:0]  warm_passes;

   bin_word_t   bin_words_pending [$];
   floor_word_t floor_expected [$];
   int          mismatches;
   int          cycle_count;

   // Stimulus bookkeeping: only bins seeded in the first pass may be revisited later.
   bit               bin_seeded [NUM_BINS];
   int               seeded_bins [$];
   bit               gen_seeding;
   logic [BIN_W-1:0] prev_bin1, prev_bin2;

   int        burst_left, gap_left;
   int        stall_left, stall_mode;
   logic [15:0] stall_pattern;

   function automatic logic [31:0] rounded_root(logic [63:0] v);
      logic [31:0] root;
      logic [31:0] trial;
      root = '0;
      for (int b = 24; b >= 0; b--) begin
         trial = root | (32'd1 << b);
         if (64'(trial) * 64'(trial) <= v) root = trial;
      end
      // Round to nearest: step up when v lies beyond root^2 + root.
      if (v - 64'(root) * 64'(root) > 64'(root)) root = root + 1;
      return root;
   endfunction

   function automatic logic [63:0] magnitude_of(logic signed [SAMPLE_BITS-1:0] x);
      logic signed [63:0] wide;
      wide = x;
      return (wide < 0) ? -wide : wide;
   endfunction

   function automatic floor_word_t track_floor(bin_word_t w);
      floor_word_t r;
      logic [63:0] re_abs, im_abs, target, prev, rate;
      logic [31:0] mag;
      re_abs = magnitude_of(w.re);
      im_abs = magnitude_of(w.im);
      mag    = rounded_root(re_abs * re_abs + im_abs * im_abs);
      target = (64'(mag) > (64'(FLOOR_MAX) >> FRAC_W)) ? 64'(FLOOR_MAX) : (64'(mag) << FRAC_W);
      r.bin   = w.bin;
      r.warm  = passes_done < warm_passes;
      r.level = '0;
      if (w.bin < NUM_BINS) begin
         if (passes_done == 0) begin
            r.level = target[FLOOR_W-1:0];
         end else begin
            prev = 64'(floor_mem[w.bin]);
            if (target < prev) rate = r.warm ? fall_warm : fall_rate;
            else rate = r.warm ? rise_warm : rise_rate;
            r.level = FLOOR_W'(((RATE_ONE - rate) * prev + rate * target + 64'd32768) >> FRAC_W);
         end
         floor_mem[w.bin] = r.level;
      end
      if (w.last && passes_done != PASS_MAX) passes_done = passes_done + 1'b1;
      return r;
   endfunction

   function automatic void csr_apply(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_RATE_DOWN_WARM: fall_warm   = data[RATE_W-1:0];
         CSR_RATE_UP_WARM:   rise_warm   = data[RATE_W-1:0];
         CSR_RATE_DOWN:      fall_rate   = data[RATE_W-1:0];
         CSR_RATE_UP:        rise_rate   = data[RATE_W-1:0];
         CSR_WARMUP_PASSES:  warm_passes = data[WARM_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic sample_kind_t pick_kind();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return MAG_ZERO;
      if (r == 1) return MAG_EXTREME;
      if (r <= 3) return MAG_SMALL;
      if (r <= 5) return MAG_MEDIUM;
      return MAG_FULL;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] random_sample(sample_kind_t kind);
      int v;
      case (kind)
         MAG_ZERO: return '0;
         MAG_EXTREME: begin
            case ($urandom_range(0, 4))
               0: return S_MIN;
               1: return S_MAX;
               2: return '1;
               3: return 1;
               default: return '0;
            endcase
         end
         MAG_SMALL: begin
            v = int'($urandom_range(0, 600)) - 300;
            return SAMPLE_BITS'(v);
         end
         MAG_MEDIUM: begin
            v = int'($urandom_range(0, 131072)) - 65536;
            return SAMPLE_BITS'(v);
         end
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   task automatic push_word(input logic [BIN_W-1:0] bin, input logic signed [SAMPLE_BITS-1:0] re,
                            input logic signed [SAMPLE_BITS-1:0] im, input logic last);
      bin_word_t w;
      w.bin  = bin;
      w.re   = re;
      w.im   = im;
      w.last = last;
      bin_words_pending.push_back(w);
      if (gen_seeding && !bin_seeded[bin]) begin
         bin_seeded[bin] = 1'b1;
         seeded_bins.push_back(int'(bin));
      end
      prev_bin2 = prev_bin1;
      prev_bin1 = bin;
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      csr_apply(idx, data);
   endtask

   task automatic wait_drained();
      while (bin_words_pending.size() != 0 || req_ch.valid || floor_expected.size() != 0)
         @(posedge clock);
      repeat (2 * LATENCY) @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.bin_index    = '0;
      req_ch.re_part      = '0;
      req_ch.im_part      = '0;
      req_ch.last_of_pass = 1'b0;
      rsp_ch.ready        = 1'b0;
      csr_write_en        = 1'b0;
      csr_index           = '0;
      csr_write_data      = '0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("** asymmetric_ema_noise_floor_top: FAILED **");
         $finish;
      end
   end

   // Sender: bursts of random length separated by random gaps, some of them empty.
   always @(posedge clock) begin
      bin_word_t taken;
      bin_word_t next_word;
      if (reset) begin
         req_ch.valid <= 1'b0;
         burst_left   <= 0;
         gap_left     <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            taken.bin  = req_ch.bin_index;
            taken.re   = req_ch.re_part;
            taken.im   = req_ch.im_part;
            taken.last = req_ch.last_of_pass;
            floor_expected.push_back(track_floor(taken));
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left != 0) begin
               gap_left     <= gap_left - 1;
               req_ch.valid <= 1'b0;
            end else if (bin_words_pending.size() != 0) begin
               next_word = bin_words_pending.pop_front();
               req_ch.bin_index    <= next_word.bin;
               req_ch.re_part      <= next_word.re;
               req_ch.im_part      <= next_word.im;
               req_ch.last_of_pass <= next_word.last;
               req_ch.valid        <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 50);
                  gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: stall behaviour changes every so often between free running, light and
   // heavy random stalls, and a fixed bit pattern.
   always @(posedge clock) begin
      logic go;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= 0;
         stall_mode   <= 0;
      end else begin
         if (stall_left == 0) begin
            stall_mode    <= $urandom_range(0, 3);
            stall_pattern <= 16'($urandom);
            stall_left    <= $urandom_range(16, 128);
         end else begin
            stall_left <= stall_left - 1;
         end
         case (stall_mode)
            0: go = 1'b1;
            1: go = ($urandom_range(0, 3) != 0);
            2: go = ($urandom_range(0, 3) == 0);
            default: go = stall_pattern[stall_left % 16];
         endcase
         rsp_ch.ready <= go;
      end
   end

   always @(posedge clock) begin
      floor_word_t want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (floor_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected result: bin %0d level %0h warm %0b", rsp_ch.out_bin,
                        rsp_ch.floor_level, rsp_ch.in_warmup);
         end else begin
            want = floor_expected.pop_front();
            if (rsp_ch.out_bin !== want.bin || rsp_ch.floor_level !== want.level ||
                rsp_ch.in_warmup !== want.warm) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("mismatch: expected bin %0d level %0h warm %0b, got bin %0d level %0h warm %0b",
                           want.bin, want.level, want.warm,
                           rsp_ch.out_bin, rsp_ch.floor_level, rsp_ch.in_warmup);
            end
         end
      end
   end

   initial begin
      int                  pass_len;
      int                  words_in_phase;
      int                  r;
      logic [BIN_W-1:0]    bin;
      sample_kind_t        kind;
      logic [RATE_W-1:0]   rates [4];
      logic [WARM_W-1:0]   warm_setting;
      logic [CSR_DATA_W-1:0] csr_value;

      passes_done = '0;
      fall_warm   = RATE_DOWN_WARM_RESET;
      rise_warm   = RATE_UP_WARM_RESET;
      fall_rate   = RATE_DOWN_RESET;
      rise_rate   = RATE_UP_RESET;
      warm_passes = WARMUP_PASSES_RESET;
      mismatches  = 0;
      cycle_count = 0;
      prev_bin1   = '0;
      prev_bin2   = '0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Seeding pass: field extremes, rounding of the root both ways, and a bin written
      // twice while still seeding.
      gen_seeding = 1'b1;
      push_word(12'd0,    S_MIN, S_MIN, 1'b0);
      push_word(12'd4095, S_MAX, S_MAX, 1'b0);
      push_word(12'd1,    0,     0,     1'b0);
      push_word(12'd2,    -1,    0,     1'b0);
      push_word(12'd3,    1,     1,     1'b0);
      push_word(12'd4,    2,     3,     1'b0);
      push_word(12'd5,    4,     2,     1'b0);
      push_word(12'd6,    S_MIN, 0,     1'b0);
      push_word(12'd7,    0,     S_MAX, 1'b0);
      push_word(12'hAAA,  24'sh2AAAAA, 24'shD55555, 1'b0);
      push_word(12'h555,  24'shEAAAAB, 24'sh155555, 1'b0);
      push_word(12'd3,    100,   -100,  1'b0);

      // The rest of the seeding pass spreads over a wide range and a tight cluster,
      // keeping clear of the bins used above.
      for (int k = 0; k < SEED_WORDS; k++) begin
         r = $urandom_range(0, 99);
         if (r < 15 && k > 0) bin = prev_bin1;
         else if (r < 55) bin = BIN_W'(100 + $urandom_range(0, 31));
         else bin = BIN_W'($urandom_range(16, 1300));
         kind = pick_kind();
         push_word(bin, random_sample(kind), random_sample(kind), k == SEED_WORDS - 1);
      end
      gen_seeding = 1'b0;

      // Second pass with warm rates: falling, rising, equal level, and the same bin
      // back to back and with one word between.
      push_word(12'd0,    1,     0,     1'b0);
      push_word(12'd0,    0,     0,     1'b0);
      push_word(12'd1,    1000,  0,     1'b0);
      push_word(12'd0,    S_MIN, S_MIN, 1'b0);
      push_word(12'd5,    4,     2,     1'b0);
      push_word(12'd4095, S_MAX, S_MAX, 1'b0);
      push_word(12'd7,    0,     S_MIN, 1'b0);
      push_word(12'd6,    0,     0,     1'b1);
      wait_drained();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               rates = '{16'd0, 16'hFFFF, 16'hFFFF, 16'd0};
               warm_setting = 4'd15;
            end
            1: begin
               rates = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
               warm_setting = 4'd0;
            end
            2: begin
               rates = '{16'd0, 16'd0, 16'd0, 16'd0};
               warm_setting = 4'd10;
            end
            3: begin
               rates = '{RATE_DOWN_WARM_RESET, RATE_UP_WARM_RESET, RATE_DOWN_RESET,
                         RATE_UP_RESET};
               warm_setting = WARMUP_PASSES_RESET;
            end
            default: begin
               foreach (rates[i]) begin
                  r = $urandom_range(0, 9);
                  rates[i] = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom);
               end
               warm_setting = WARM_W'($urandom_range(0, 15));
            end
         endcase
         write_register(CSR_RATE_DOWN_WARM, rates[0]);
         write_register(CSR_RATE_UP_WARM, rates[1]);
         write_register(CSR_RATE_DOWN, rates[2]);
         write_register(CSR_RATE_UP, rates[3]);
         // Bits above the pass count must be ignored.
         csr_value = 16'($urandom);
         csr_value[WARM_W-1:0] = warm_setting;
         write_register(CSR_WARMUP_PASSES, csr_value);
         // An index past the last register must change nothing.
         write_register(CSR_WARMUP_PASSES + CSR_INDEX_W'($urandom_range(1, 3)), 16'($urandom));
         @(posedge clock);
         csr_write_en <= 1'b0;

         // Well-formed passes over seeded bins, with frequent repeats of recent bins and
         // the occasional stray end-of-pass flag.
         words_in_phase = 0;
         while (words_in_phase < PHASE_WORDS) begin
            pass_len = $urandom_range(4, 60);
            for (int k = 0; k < pass_len; k++) begin
               r = $urandom_range(0, 99);
               if (r < 25) bin = prev_bin1;
               else if (r < 35) bin = prev_bin2;
               else bin = BIN_W'(seeded_bins[$urandom_range(0, seeded_bins.size() - 1)]);
               kind = pick_kind();
               push_word(bin, random_sample(kind), random_sample(kind),
                         (k == pass_len - 1) || ($urandom_range(0, 99) < 3));
               words_in_phase++;
            end
         end
         wait_drained();
      end

      if (floor_expected.size() != 0) begin
         mismatches += floor_expected.size();
         $display("%0d expected results never arrived", floor_expected.size());
      end
      if (mismatches == 0) begin
         $display("** asymmetric_ema_noise_floor_top: PASSED **");
      end else begin
         $display("** asymmetric_ema_noise_floor_top: FAILED **");
      end
      $finish;
   end

endmodule
